// ----- design/mmp_pkg.sv -----
// Shared types, constants and codes for the modular matrix power block.
// No dependencies; every other file of the block imports this package.
package mmp_pkg;

    localparam int unsigned MP_MAX_DIM    = 32;
    localparam int unsigned MP_IDX_W      = (MP_MAX_DIM > 1) ? $clog2(MP_MAX_DIM) : 1;
    localparam int unsigned MP_ADDR_W     = 2 * MP_IDX_W;

    localparam int unsigned VAL_W         = 31;
    localparam int unsigned ROWCOL_W      = 5;
    localparam int unsigned DIM_W         = 6;
    localparam int unsigned PROD_W        = 2 * VAL_W;
    localparam int unsigned BITS_PER_CELL = 2;
    localparam int unsigned N_CELLS       = PROD_W / BITS_PER_CELL;
    localparam int unsigned CFG_AW        = 4;
    localparam int unsigned DRAIN_CYC     = N_CELLS + 3;
    localparam int unsigned DRAIN_W       = $clog2(DRAIN_CYC + 1);

    // word operation codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_POWER = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_EXPONENT  = 2'd1;
    localparam logic [1:0] REG_DIMENSION = 2'd2;

    localparam logic [VAL_W-1:0] MOD_RESET = 31'd1000000007;
    localparam logic [VAL_W-1:0] EXP_RESET = 31'd1;
    localparam logic [DIM_W-1:0] DIM_RESET = 6'd24;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mmp_tag_t;

    typedef struct packed {
        logic [VAL_W-1:0] modulus;
        logic [VAL_W-1:0] exponent;
        logic [DIM_W-1:0] dimension;
    } mmp_cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR,
        ST_RD,
        ST_ROUND,
        ST_MUL,
        ST_DRAIN,
        ST_COPY,
        ST_COPY_END
    } mmp_state_t;

endpackage

// ----- design/mmp_req_if.sv -----
// Request channel: one word carries an operation, an entry index and a value.
// Depends on mmp_pkg.
interface mmp_req_if import mmp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] col;
    logic [VAL_W-1:0]    value;

    modport source (output valid, output op, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input value,
                    output ready);
endinterface

// ----- design/mmp_rsp_if.sv -----
// Response channel: one word carries read data and a status bit.
// Depends on mmp_pkg.
interface mmp_rsp_if import mmp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] data;
    logic             status;

    modport source (output valid, output data, output status, input ready);
    modport sink   (input valid, input data, input status, output ready);
endinterface

// ----- design/modular_matrix_power.sv -----
// Words are handled one at a time. A power word runs one matrix product for each
// set exponent bit and one squaring per bit below the top.
// The shared multiplier issues one a*b term a cycle into a 31-cell reduction chain.
// Reset: configuration to its defaults; the result reads as the identity.
module modular_matrix_power import mmp_pkg::*;
#(
    parameter int unsigned MAX_DIM = MP_MAX_DIM
)
(
    input  logic              clk,
    input  logic              rst_n,
    mmp_req_if.sink           req,
    mmp_rsp_if.source         rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int unsigned IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned ADDR_W = 2 * IDX_W;
    localparam int unsigned DEPTH  = 1 << ADDR_W;
    localparam int unsigned NW     = $clog2(MAX_DIM + 1);
    localparam int unsigned CW     = (NW > ROWCOL_W) ? NW : ROWCOL_W;

    mmp_cfg_t cfg;

    mmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective modulus and dimension
    logic [VAL_W-1:0] mod_eff;
    logic [NW-1:0]    n_eff;
    logic [IDX_W-1:0] nm1;

    always_comb
    begin
        mod_eff = (cfg.modulus == '0) ? VAL_W'(1) : cfg.modulus;
        if (cfg.dimension == '0)
            n_eff = NW'(1);
        else if (7'(cfg.dimension) > 7'(MAX_DIM))
            n_eff = NW'(MAX_DIM);
        else
            n_eff = NW'(cfg.dimension);
        nm1 = IDX_W'(n_eff - NW'(1));
    end

    mmp_state_t        state_reg;
    mmp_state_t        state_next;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  k_reg;
    logic [VAL_W-1:0]  exp_reg;
    logic              res_ident_reg;
    logic [NW-1:0]     res_dim_reg;
    logic              sq_base_reg;
    logic              phase_sq_reg;
    logic [DRAIN_W-1:0] drain_reg;

    logic              rsp_valid_reg;
    logic [VAL_W-1:0]  rsp_data_reg;
    logic              rsp_status_reg;

    // request decode
    logic             req_fire;
    logic             req_oob;
    logic             rd_zero;
    logic [IDX_W-1:0] req_r;
    logic [IDX_W-1:0] req_c;
    logic             i_last;
    logic             j_last;
    logic             k_last;
    logic             round_skip;

    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign req_oob   = (CW'(req.row) >= CW'(n_eff)) || (CW'(req.col) >= CW'(n_eff));
    assign rd_zero   = (CW'(req.row) >= CW'(res_dim_reg)) ||
                       (CW'(req.col) >= CW'(res_dim_reg));
    assign req_r     = IDX_W'(req.row);
    assign req_c     = IDX_W'(req.col);
    assign i_last    = (i_reg == nm1);
    assign j_last    = (j_reg == nm1);
    assign k_last    = (k_reg == nm1);
    // a round with nothing to do: clear bit without product, or final squaring
    assign round_skip = (!phase_sq_reg && !exp_reg[0]) ||
                        (phase_sq_reg && (exp_reg[VAL_W-1:1] == '0));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.op)
                        OP_WRITE: state_next = req_oob ? ST_IDLE : ST_WR;
                        OP_POWER: state_next = ST_ROUND;
                        OP_READ:
                        begin
                            if (!req_oob && !rd_zero && !res_ident_reg)
                                state_next = ST_RD;
                        end
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WR:       if (drain_reg == '0) state_next = ST_IDLE;
            ST_RD:       state_next = ST_IDLE;
            ST_ROUND:
            begin
                if (exp_reg == '0)
                    state_next = ST_IDLE;
                else if (!round_skip)
                    state_next = ST_MUL;
            end
            ST_MUL:      if (i_last && j_last && k_last) state_next = ST_DRAIN;
            ST_DRAIN:    if (drain_reg == '0) state_next = ST_COPY;
            ST_COPY:     if (i_last && j_last) state_next = ST_COPY_END;
            ST_COPY_END: state_next = ST_ROUND;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    logic             load_out;
    logic [VAL_W-1:0] out_data_n;
    logic             out_status_n;
    logic             issue;
    logic             wr_inject;
    logic [VAL_W-1:0] res_q;

    always_comb
    begin
        load_out     = 1'b0;
        out_data_n   = '0;
        out_status_n = 1'b0;
        issue        = (state_reg == ST_MUL);
        wr_inject    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.op)
                        OP_WRITE:
                        begin
                            load_out     = req_oob;
                            out_status_n = req_oob;
                            wr_inject    = !req_oob;
                        end
                        OP_POWER: load_out = 1'b0;
                        OP_READ:
                        begin
                            if (req_oob)
                            begin
                                load_out     = 1'b1;
                                out_status_n = 1'b1;
                            end
                            else if (rd_zero)
                                load_out = 1'b1;
                            else if (res_ident_reg)
                            begin
                                load_out   = 1'b1;
                                out_data_n = VAL_W'(req.row == req.col);
                            end
                        end
                        default: load_out = 1'b1;
                    endcase
                end
            end
            ST_WR:    load_out = (drain_reg == '0);
            ST_RD:
            begin
                load_out   = 1'b1;
                out_data_n = res_q;
            end
            ST_ROUND: load_out = (exp_reg == '0);
            default:  load_out = 1'b0;
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            exp_reg       <= '0;
            res_ident_reg <= 1'b1;
            res_dim_reg   <= NW'(MAX_DIM);
            sq_base_reg   <= 1'b1;
            phase_sq_reg  <= 1'b0;
            drain_reg     <= DRAIN_W'(DRAIN_CYC);
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg != ST_WR && state_reg != ST_DRAIN)
                drain_reg <= DRAIN_W'(DRAIN_CYC);
            else if (drain_reg != '0)
                drain_reg <= drain_reg - DRAIN_W'(1);

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && req.op == OP_POWER)
                    begin
                        exp_reg       <= cfg.exponent;
                        res_ident_reg <= 1'b1;
                        res_dim_reg   <= n_eff;
                        sq_base_reg   <= 1'b1;
                        phase_sq_reg  <= 1'b0;
                        i_reg         <= '0;
                        j_reg         <= '0;
                        k_reg         <= '0;
                    end
                end
                ST_ROUND:
                begin
                    if (exp_reg != '0)
                    begin
                        if (!phase_sq_reg && !exp_reg[0])
                            phase_sq_reg <= 1'b1;
                        else if (phase_sq_reg && exp_reg[VAL_W-1:1] == '0)
                        begin
                            exp_reg      <= '0;
                            phase_sq_reg <= 1'b0;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (k_last)
                    begin
                        k_reg <= '0;
                        if (j_last)
                        begin
                            j_reg <= '0;
                            i_reg <= i_last ? '0 : i_reg + IDX_W'(1);
                        end
                        else
                            j_reg <= j_reg + IDX_W'(1);
                    end
                    else
                        k_reg <= k_reg + IDX_W'(1);
                end
                ST_COPY:
                begin
                    if (j_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_last ? '0 : i_reg + IDX_W'(1);
                    end
                    else
                        j_reg <= j_reg + IDX_W'(1);
                end
                ST_COPY_END:
                begin
                    if (phase_sq_reg)
                    begin
                        sq_base_reg  <= 1'b0;
                        exp_reg      <= exp_reg >> 1;
                        phase_sq_reg <= 1'b0;
                    end
                    else
                    begin
                        res_ident_reg <= 1'b0;
                        phase_sq_reg  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_data_reg   <= out_data_n;
            rsp_status_reg <= out_status_n;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.data   = rsp_data_reg;
    assign rsp.status = rsp_status_reg;

    // stage 1: issue a term or a write, read operands
    mmp_tag_t          s1_tag_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_one_reg;
    logic              s1_wr_reg;
    logic [VAL_W-1:0]  s1_val_reg;
    logic [ADDR_W-1:0] xa;
    logic [ADDR_W-1:0] ya;
    logic [ADDR_W-1:0] res_ra;

    assign xa     = {i_reg, k_reg};
    assign ya     = {k_reg, j_reg};
    assign res_ra = (state_reg == ST_IDLE) ? {req_r, req_c} : xa;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_tag_reg <= '0;
        else
        begin
            s1_tag_reg.valid <= issue || wr_inject;
            s1_tag_reg.first <= wr_inject || (k_reg == '0);
            s1_tag_reg.last  <= wr_inject || k_last;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= wr_inject ? {req_r, req_c} : {i_reg, j_reg};
        s1_one_reg  <= (i_reg == k_reg);
        s1_wr_reg   <= wr_inject;
        s1_val_reg  <= req.value;
    end

    // stage 2: select operands, multiply
    logic [VAL_W-1:0]  base_qa;
    logic [VAL_W-1:0]  base_qb;
    logic [VAL_W-1:0]  scr_qa;
    logic [VAL_W-1:0]  scr_qb;
    logic [VAL_W-1:0]  xop;
    logic [VAL_W-1:0]  yop;
    mmp_tag_t          s2_tag_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [PROD_W-1:0] s2_p_reg;

    always_comb
    begin
        if (phase_sq_reg)
            xop = sq_base_reg ? base_qa : scr_qa;
        else
            xop = res_ident_reg ? VAL_W'(s1_one_reg) : res_q;
        yop = sq_base_reg ? base_qb : scr_qb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_tag_reg <= '0;
        else
            s2_tag_reg <= s1_tag_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_addr_reg <= s1_addr_reg;
        s2_p_reg    <= s1_wr_reg ? PROD_W'(s1_val_reg) : PROD_W'(xop) * PROD_W'(yop);
    end

    // reduce each product modulo m
    logic [VAL_W-1:0]  ch_r;
    mmp_tag_t          ch_tag;
    logic [ADDR_W-1:0] ch_addr;

    mmp_chain #(.ADDR_W(ADDR_W)) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .m        (mod_eff),
        .p_in     (s2_p_reg),
        .tag_in   (s2_tag_reg),
        .addr_in  (s2_addr_reg),
        .r_out    (ch_r),
        .tag_out  (ch_tag),
        .addr_out (ch_addr)
    );

    // accumulate terms, reducing after each
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] acc_next;
    logic [VAL_W:0]   sum;
    logic             base_we;
    logic             prod_we;

    always_comb
    begin
        sum = {1'b0, (ch_tag.first ? '0 : acc_reg)} + {1'b0, ch_r};
        if (sum >= {1'b0, mod_eff})
            sum = sum - {1'b0, mod_eff};
        acc_next = sum[VAL_W-1:0];
        base_we  = ch_tag.valid && ch_tag.last && (state_reg == ST_WR);
        prod_we  = ch_tag.valid && ch_tag.last && (state_reg != ST_WR);
    end

    always_ff @(posedge clk)
    begin
        if (ch_tag.valid)
            acc_reg <= acc_next;
    end

    // copy product buffer into result or running power
    logic              cp_v_reg;
    logic [ADDR_W-1:0] cp_addr_reg;
    logic [VAL_W-1:0]  prod_q;
    logic              scr_we;
    logic              res_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cp_v_reg <= 1'b0;
        else
            cp_v_reg <= (state_reg == ST_COPY);
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg <= {i_reg, j_reg};
    end

    assign scr_we = cp_v_reg && phase_sq_reg;
    assign res_we = cp_v_reg && !phase_sq_reg;

    // matrix stores
    logic [VAL_W-1:0] base_mem [DEPTH];
    logic [VAL_W-1:0] scr_mem  [DEPTH];
    logic [VAL_W-1:0] res_mem  [DEPTH];
    logic [VAL_W-1:0] prod_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (base_we)
            base_mem[ch_addr] <= acc_next;
        base_qa <= base_mem[xa];
        base_qb <= base_mem[ya];
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
            scr_mem[cp_addr_reg] <= prod_q;
        scr_qa <= scr_mem[xa];
        scr_qb <= scr_mem[ya];
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[cp_addr_reg] <= prod_q;
        res_q <= res_mem[res_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prod_we)
            prod_mem[ch_addr] <= acc_next;
        prod_q <= prod_mem[{i_reg, j_reg}];
    end

endmodule

// ----- design/mmp_regs.sv -----
// APB-style configuration registers: modulus, exponent, dimension.
// Depends on mmp_pkg.
module mmp_regs import mmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mmp_cfg_t          cfg
);

    mmp_cfg_t   cfg_reg;
    mmp_cfg_t   cfg_next;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // decode write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_MODULUS:   cfg_next.modulus   = pwdata[VAL_W-1:0];
                REG_EXPONENT:  cfg_next.exponent  = pwdata[VAL_W-1:0];
                REG_DIMENSION: cfg_next.dimension = pwdata[DIM_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modulus   <= MOD_RESET;
            cfg_reg.exponent  <= EXP_RESET;
            cfg_reg.dimension <= DIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_MODULUS:   prdata = 32'(cfg_reg.modulus);
            REG_EXPONENT:  prdata = 32'(cfg_reg.exponent);
            REG_DIMENSION: prdata = 32'(cfg_reg.dimension);
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- design/mmp_cell.sv -----
// One cell of the reduction chain: folds two product bits into a running
// remainder modulo m and hands remainder, product and tag on. Depends on mmp_pkg.
module mmp_cell import mmp_pkg::*;
#(
    parameter int unsigned ADDR_W = MP_ADDR_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [VAL_W-1:0]  m,
    input  logic [VAL_W-1:0]  r_in,
    input  logic [PROD_W-1:0] p_in,
    input  mmp_tag_t          tag_in,
    input  logic [ADDR_W-1:0] addr_in,
    output logic [VAL_W-1:0]  r_out,
    output logic [PROD_W-1:0] p_out,
    output mmp_tag_t          tag_out,
    output logic [ADDR_W-1:0] addr_out
);

    logic [VAL_W-1:0]  r_reg;
    logic [VAL_W-1:0]  r_next;
    logic [PROD_W-1:0] p_reg;
    mmp_tag_t          tag_reg;
    logic [ADDR_W-1:0] addr_reg;

    // one restoring step: shift in a bit, subtract m once if it fits
    function automatic logic [VAL_W-1:0] mod_step(input logic [VAL_W-1:0] r,
                                                  input logic b,
                                                  input logic [VAL_W-1:0] md);
        logic [VAL_W:0] t;
        t = {r, b};
        if (t >= {1'b0, md})
            t = t - {1'b0, md};
        return t[VAL_W-1:0];
    endfunction

    always_comb
    begin
        r_next = r_in;
        for (int b = 0; b < BITS_PER_CELL; b++)
            r_next = mod_step(r_next, p_in[PROD_W-1-b], m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_reg <= '0;
        else
            tag_reg <= tag_in;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        p_reg    <= p_in << BITS_PER_CELL;
        addr_reg <= addr_in;
    end

    assign r_out    = r_reg;
    assign p_out    = p_reg;
    assign tag_out  = tag_reg;
    assign addr_out = addr_reg;

endmodule

// ----- design/mmp_chain.sv -----
// Row of reduction cells: turns a 62-bit product into its remainder modulo m,
// one new product a cycle. Depends on mmp_pkg and mmp_cell.
module mmp_chain import mmp_pkg::*;
#(
    parameter int unsigned ADDR_W = MP_ADDR_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [VAL_W-1:0]  m,
    input  logic [PROD_W-1:0] p_in,
    input  mmp_tag_t          tag_in,
    input  logic [ADDR_W-1:0] addr_in,
    output logic [VAL_W-1:0]  r_out,
    output mmp_tag_t          tag_out,
    output logic [ADDR_W-1:0] addr_out
);

    logic [VAL_W-1:0]  r_w    [N_CELLS+1];
    logic [PROD_W-1:0] p_w    [N_CELLS+1];
    mmp_tag_t          tag_w  [N_CELLS+1];
    logic [ADDR_W-1:0] addr_w [N_CELLS+1];

    // the remainder starts at zero
    assign r_w[0]    = '0;
    assign p_w[0]    = p_in;
    assign tag_w[0]  = tag_in;
    assign addr_w[0] = addr_in;

    for (genvar c = 0; c < N_CELLS; c++)
    begin : g_cell
        mmp_cell #(.ADDR_W(ADDR_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .m        (m),
            .r_in     (r_w[c]),
            .p_in     (p_w[c]),
            .tag_in   (tag_w[c]),
            .addr_in  (addr_w[c]),
            .r_out    (r_w[c+1]),
            .p_out    (p_w[c+1]),
            .tag_out  (tag_w[c+1]),
            .addr_out (addr_w[c+1])
        );
    end

    assign r_out    = r_w[N_CELLS];
    assign tag_out  = tag_w[N_CELLS];
    assign addr_out = addr_w[N_CELLS];

endmodule
